### hw/rtl/bintset_pkg.sv
// Shared types, codes and defaults for the bounded integer set table.
package bintset_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int CAP_W = 7;
	localparam int POS_W = 6;
	localparam int CNT_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		ACT_TEST   = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		status_t          status;
		logic [CNT_W-1:0] element_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_RD_LAST,
		S_WR_LAST,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic rd_last;
		logic wr_last;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;
		logic scan_hit;
		logic act_remove;
	} sts_t;

endpackage

### hw/rtl/bintset_ctrl.sv
// Controller state machine that sequences the scan, the swap-with-last and the result.
module bintset_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bintset_pkg::sts_t   sts,
	output bintset_pkg::cmd_t   cmd,
	output logic                busy
);
	import bintset_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					if (sts.scan_hit && sts.act_remove) state_nxt = S_RD_LAST;
					else state_nxt = S_FINISH;
				end
			end
			S_RD_LAST: state_nxt = S_WR_LAST;
			S_WR_LAST: state_nxt = S_FINISH;
			S_FINISH:  state_nxt = S_IDLE;
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_SCAN:    cmd.scan    = 1'b1;
			S_RD_LAST: cmd.rd_last = 1'b1;
			S_WR_LAST: cmd.wr_last = 1'b1;
			S_FINISH:  cmd.finish  = 1'b1;
			default:   busy        = 1'b1;
		endcase
	end

endmodule

### hw/rtl/bintset_dp.sv
// Datapath: entry memory, scan pipeline, element count, capacity register and result register.
module bintset_dp #(
	parameter int SET_DEPTH = bintset_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bintset_pkg::cmd_t              cmd,
	output bintset_pkg::sts_t              sts,
	input  bintset_pkg::req_t              req,
	input  logic                           cfg_we,
	input  logic [bintset_pkg::CAP_W-1:0]  cfg_data,
	output logic                           done,
	output bintset_pkg::rsp_t              rsp
);
	import bintset_pkg::*;

	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	logic [31:0] mem [SET_DEPTH];
	logic [31:0] rdata_s1;

	action_t            act_q;
	logic signed [31:0] value_q;
	logic [AW-1:0]      rd_idx_q;
	logic [AW-1:0]      cmp_idx_s1;
	logic               cmp_vld_s1;
	logic               hit_q;
	logic [AW-1:0]      hit_idx_q;
	logic [CW-1:0]      count_q;
	logic [CAP_W-1:0]   cap_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic [AW-1:0] last_idx;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          wr_en;
	logic          match;
	logic          miss;
	logic [LW-1:0] cap_ext;
	logic [LW-1:0] limit;
	logic          full;
	logic [CW-1:0] count_nxt;
	status_t       status_nxt;

	assign last_idx = AW'(count_q - CW'(1));
	assign match    = cmp_vld_s1 && (rdata_s1 == value_q);
	assign miss     = (count_q == '0) || (cmp_vld_s1 && (cmp_idx_s1 == last_idx));

	assign sts.scan_end   = match || miss;
	assign sts.scan_hit   = match;
	assign sts.act_remove = (act_q == ACT_REMOVE);

	// Capacity above the table depth saturates to the depth.
	assign cap_ext = LW'(cap_q);
	assign limit   = (cap_ext > LW'(SET_DEPTH)) ? LW'(SET_DEPTH) : cap_ext;
	assign full    = LW'(count_q) >= limit;

	assign rd_addr = cmd.rd_last ? last_idx : rd_idx_q;
	assign wr_en   = cmd.wr_last || (cmd.finish && (act_q == ACT_ADD) && !hit_q && !full);
	assign wr_addr = cmd.wr_last ? hit_idx_q : AW'(count_q);
	assign wr_data = cmd.wr_last ? rdata_s1 : value_q;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		unique case (act_q)
			ACT_TEST: begin
				status_nxt = hit_q ? ST_DONE : ST_ABSENT;
			end
			ACT_ADD: begin
				priority if (hit_q) begin
					status_nxt = ST_PRESENT;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + CW'(1);
				end
			end
			ACT_REMOVE: begin
				if (hit_q) count_nxt = count_q - CW'(1);
				else status_nxt = ST_ABSENT;
			end
			ACT_CLEAR: begin
				count_nxt = '0;
			end
			default: status_nxt = ST_DONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			count_q    <= '0;
			cap_q      <= CAP_RESET;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cfg_we) cap_q <= cfg_data;
			if (cmd.load) begin
				rd_idx_q   <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else if (cmd.scan) begin
				rd_idx_q   <= rd_idx_q + AW'(1);
				cmp_vld_s1 <= 1'b1;
				if (match) hit_q <= 1'b1;
			end
			if (cmd.finish) count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= req.action;
			value_q <= req.value;
		end
		if (cmd.scan) begin
			cmp_idx_s1 <= rd_idx_q;
			if (match) hit_idx_q <= cmp_idx_s1;
		end
		if (cmd.finish) begin
			rsp_q.found         <= hit_q;
			rsp_q.position      <= hit_q ? POS_W'(hit_idx_q) : '0;
			rsp_q.status        <= status_nxt;
			rsp_q.element_count <= CNT_W'(count_nxt);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### hw/rtl/bounded_integer_set_table_unit.sv
// Top level of the bounded integer set table: controller, datapath and checks.
//
// Usage: drive req (action and value) with start; the request is taken at a
// rising edge where start is high and busy is low. Each request returns one
// result on rsp, valid for exactly the one cycle in which done is high; the
// receiver cannot hold it off, so it must capture it then.
// The set lives in a single-port-read, single-port-write memory of SET_DEPTH
// entries. A request scans the live entries one per cycle through the
// registered read port and stops early on a match. A remove that hits
// then reads the last entry and writes it into the hole. A new request may
// be accepted in the cycle done is high. The capacity register is to be
// written through cfg_we and cfg_data only while the block is idle; the user
// must keep to this, as the block itself does not enforce it. Reset clears
// the set to empty and sets the capacity to 64; no memory clearing is
// needed after reset.
module bounded_integer_set_table_unit #(
	parameter int SET_DEPTH = bintset_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bintset_pkg::req_t              req,
	output logic                           done,
	output bintset_pkg::rsp_t              rsp,
	input  logic                           cfg_we,
	input  logic [bintset_pkg::CAP_W-1:0]  cfg_data
);
	import bintset_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bintset_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bintset_dp #(
		.SET_DEPTH (SET_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.rsp      (rsp)
	);

`ifndef NO_ASSERTIONS
	// A result only follows a cycle in which the block was working.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	// An accepted request makes the block busy in the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// A refused add never reports a match.
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> !rsp.found)
		else $error("full status with found set");

	// A found value never reports absent or full.
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.found) |-> (rsp.status == ST_DONE || rsp.status == ST_PRESENT))
		else $error("found value with absent or full status");
`endif

endmodule

### bench/tb_bounded_integer_set_table_unit.sv
// Self-checking testbench for the bounded integer set table unit.
`timescale 1ns / 100ps

module tb_bounded_integer_set_table_unit;
	import bintset_pkg::*;

	localparam int SET_DEPTH = DEPTH_DEF;
	localparam int POOL_SIZE = 96;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_data;

	// Shadow copy of the set contents and the capacity register.
	logic [31:0] shadow_entries [SET_DEPTH];
	int shadow_size;
	logic [CAP_W-1:0] shadow_capacity;

	rsp_t pending_results [$];
	logic [31:0] value_pool [POOL_SIZE];
	int mismatch_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit start_lowered = 1'b1;

	bounded_integer_set_table_unit #(
		.SET_DEPTH(SET_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one request to the shadow set and returns the response it should produce.
	function automatic rsp_t apply_to_shadow_set(req_t r);
		rsp_t o;
		int hit_at;
		int lim;
		int i;
		hit_at = -1;
		for (i = 0; i < shadow_size && hit_at < 0; i++) begin
			if (shadow_entries[i] == r.value)
				hit_at = i;
		end
		lim = (shadow_capacity > SET_DEPTH) ? SET_DEPTH : int'(shadow_capacity);
		o.found = (hit_at >= 0);
		o.position = (hit_at >= 0) ? hit_at[POS_W-1:0] : '0;
		case (r.action)
			ACT_TEST: begin
				o.status = (hit_at >= 0) ? ST_DONE : ST_ABSENT;
			end
			ACT_ADD: begin
				if (hit_at >= 0) begin
					o.status = ST_PRESENT;
				end else if (shadow_size >= lim) begin
					o.status = ST_FULL;
				end else begin
					shadow_entries[shadow_size] = r.value;
					shadow_size++;
					o.status = ST_DONE;
				end
			end
			ACT_REMOVE: begin
				if (hit_at >= 0) begin
					shadow_entries[hit_at] = shadow_entries[shadow_size - 1];
					shadow_size--;
					o.status = ST_DONE;
				end else begin
					o.status = ST_ABSENT;
				end
			end
			default: begin
				shadow_size = 0;
				o.status = ST_DONE;
			end
		endcase
		o.element_count = shadow_size[CNT_W-1:0];
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	task automatic note_mismatch(input string msg);
		if (mismatch_count < 10)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got)
			note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	task automatic lower_start();
		if (!start_lowered) begin
			start <= 1'b0;
			start_lowered = 1'b1;
		end
	endtask

	// Holds start high until the request is taken, then predicts its response.
	task automatic send_request(input action_t act, input logic [31:0] val);
		req_t r;
		int gap;
		r.action = act;
		r.value = val;
		req <= r;
		start <= 1'b1;
		start_lowered = 1'b0;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_to_shadow_set(r));
		gap = pick_gap();
		if (gap > 0) begin
			lower_start();
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every response is back and the block is idle.
	task automatic wait_for_quiet();
		lower_start();
		do @(negedge clk); while (pending_results.size() != 0 || busy);
		@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_for_quiet();
		cfg_we <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_capacity = cap;
	endtask

	task automatic test_basic_operations();
		send_request(ACT_TEST, 32'd5);
		send_request(ACT_CLEAR, 32'd5);
		send_request(ACT_ADD, 32'h8000_0000);
		send_request(ACT_ADD, 32'h7FFF_FFFF);
		send_request(ACT_ADD, 32'h0000_0000);
		send_request(ACT_ADD, 32'hFFFF_FFFF);
		send_request(ACT_ADD, 32'h8000_0000);
		send_request(ACT_TEST, 32'hFFFF_FFFF);
		// Removing the first entry moves the last one into its slot.
		send_request(ACT_REMOVE, 32'h8000_0000);
		send_request(ACT_TEST, 32'hFFFF_FFFF);
		send_request(ACT_REMOVE, 32'd5);
		send_request(ACT_REMOVE, 32'h0000_0000);
		send_request(ACT_TEST, 32'h7FFF_FFFF);
		// A clear still reports where the value sat before the set was emptied.
		send_request(ACT_CLEAR, 32'h7FFF_FFFF);
	endtask

	task automatic test_capacity_limits();
		write_capacity(7'd0);
		send_request(ACT_ADD, 32'd1);
		write_capacity(7'd2);
		send_request(ACT_ADD, 32'd10);
		send_request(ACT_ADD, 32'd20);
		send_request(ACT_ADD, 32'd30);
		send_request(ACT_ADD, 32'd10);
		// Shrinking below the current count keeps the entries but refuses new ones.
		write_capacity(7'd1);
		send_request(ACT_ADD, 32'd40);
		send_request(ACT_REMOVE, 32'd10);
		send_request(ACT_ADD, 32'd40);
		send_request(ACT_REMOVE, 32'd20);
		send_request(ACT_ADD, 32'd40);
		write_capacity(7'd127);
		send_request(ACT_TEST, 32'd40);
	endtask

	task automatic test_random_phases();
		int phase;
		int n;
		int i;
		int pick;
		int add_pct;
		int clear_pct;
		logic [CAP_W-1:0] cap;
		action_t act;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom();
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin cap = 7'd127; add_pct = 80; clear_pct = 0; end
				1: begin cap = 7'd64;  add_pct = 50; clear_pct = 1; end
				2: begin cap = 7'd17;  add_pct = 55; clear_pct = 1; end
				3: begin cap = 7'd1;   add_pct = 40; clear_pct = 1; end
				4: begin cap = 7'd65;  add_pct = 60; clear_pct = 1; end
				default: begin
					cap = CAP_W'($urandom_range(0, 127));
					add_pct = 50;
					clear_pct = 1;
				end
			endcase
			write_capacity(cap);
			for (n = 0; n < 125; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < clear_pct)
					act = ACT_CLEAR;
				else if (pick < clear_pct + add_pct)
					act = ACT_ADD;
				else if (pick[0])
					act = ACT_TEST;
				else
					act = ACT_REMOVE;
				send_request(act, pick_value());
				if ($urandom_range(0, 59) == 0)
					wait_for_quiet();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		shadow_size = 0;
		shadow_capacity = CAP_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_operations();
		test_capacity_limits();
		test_random_phases();
		wait_for_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	always @(posedge clk) begin : result_check
		rsp_t expected;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf(
					"response with no request pending: found=%0b position=%0d code=%0d count=%0d",
					rsp.found, rsp.position, rsp.status, rsp.element_count));
			end else begin
				expected = pending_results.pop_front();
				check_field("found", expected.found, rsp.found);
				check_field("position", expected.position, rsp.position);
				check_field("status", expected.status, rsp.status);
				check_field("element_count", expected.element_count, rsp.element_count);
			end
		end
	end

	// Ends the run if neither a request nor a response moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

### sim.f
hw/rtl/bintset_pkg.sv
hw/rtl/bintset_ctrl.sv
hw/rtl/bintset_dp.sv
hw/rtl/bounded_integer_set_table_unit.sv
bench/tb_bounded_integer_set_table_unit.sv
